// ===== design/radix_digit_string_converter_unit_defines.svh =====
// Assertion macros used by the checker file of the radix digit string converter.
`ifndef RADIX_DIGIT_STRING_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_DIGIT_STRING_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RDSC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdsc assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RDSC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdsc assertion failed");

`endif

// ===== design/rdsc_pkg.sv =====
// Package with the types, constants and helper functions of the radix digit converter.
`timescale 1ns / 1ps

package rdsc_pkg;

  localparam int VALUE_BITS = 64;
  localparam int RADIX_BITS = 6;
  localparam int CHAR_BITS  = 7;
  localparam int REM_W      = 6;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO     = 7'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE     = 7'd57;
  localparam logic [CHAR_BITS-1:0] LETTER_OFFSET = 7'd87;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } rdsc_state_t;

  typedef struct packed {
    logic                  start;
    logic [RADIX_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_rsp_t;

  // Radix values outside 2..36 are pulled to the nearest end of the range.
  function automatic logic [RADIX_BITS-1:0] radix_clamp(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Digit values below ten become '0'..'9', larger ones 'a' onward.
  function automatic logic [CHAR_BITS-1:0] digit_char_f(input logic [REM_W-1:0] d);
    logic [CHAR_BITS-1:0] wide;
    logic [CHAR_BITS-1:0] res;
    wide = {1'b0, d};
    if (wide + CHAR_ZERO <= CHAR_NINE) begin
      res = wide + CHAR_ZERO;
    end else begin
      res = wide + LETTER_OFFSET;
    end
    return res;
  endfunction

endpackage

// ===== design/rdsc_ifs.sv =====
// Valid/ready channel interfaces for the input items and the result digits.
`timescale 1ns / 1ps

interface rdsc_in_if import rdsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_BITS-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink (input valid, input value, input radix, output ready);
endinterface

interface rdsc_out_if import rdsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== design/rdsc_div.sv =====
// Bit-serial restoring divider of a value by a small radix, one quotient bit per cycle.
`timescale 1ns / 1ps

module rdsc_div import rdsc_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  div_req_t               req,
  input  logic [VALUE_WIDTH-1:0] dividend,
  output div_rsp_t               rsp,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [REM_W-1:0]       remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_r;
  logic [REM_W-1:0]       rem_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [REM_W:0]         shifted;
  logic [REM_W:0]         diff;
  logic                   fits;
  logic [REM_W-1:0]       rem_nxt;

  // The partial remainder stays below the divisor, so one more bit fits in REM_W+1 bits.
  always_comb begin
    shifted = {rem_r, quo_r[VALUE_WIDTH-1]};
    fits    = (shifted >= {1'b0, req.divisor});
    diff    = shifted - {1'b0, req.divisor};
    rem_nxt = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CW'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_WIDTH-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quo_zero = (quo_r == '0);
  assign quotient     = quo_r;
  assign remainder    = rem_r;

endmodule

// ===== design/radix_digit_string_converter_unit.sv =====
// Top level of the radix digit string converter: control, digit buffer and output stage.
`timescale 1ns / 1ps

// The unit takes one unsigned value and a radix per input transfer and returns the
// digits of the value in that radix as ASCII characters, most significant digit first,
// one digit per output transfer, with last set on the final digit. Digits 0..9 come
// out as '0'..'9' and larger digits as 'a'..'z'; a value of zero gives the single
// digit '0', and no leading zeros are produced. A radix below 2 is treated as 2 and
// a radix above 36 as 36; only the low VALUE_WIDTH bits of the value are used.
// Each digit is found by a bit-serial division that shifts one quotient bit per
// cycle. The digits are collected least significant first in a small buffer memory
// and then read back in reverse order, each digit passing through a read state and
// then a show state that waits for the sink. The unit works on one item at a
// time: the input is ready only while no digit of the previous item is pending.

module radix_digit_string_converter_unit import rdsc_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rdsc_in_if.sink    in_ch,
  rdsc_out_if.source out_ch
);

  localparam int AW = $clog2(VALUE_WIDTH);

  rdsc_state_t            state_r;
  rdsc_state_t            state_nxt;
  logic [RADIX_BITS-1:0]  radix_r;
  logic [AW-1:0]          ndig_r;
  logic [AW-1:0]          ndig_nxt;
  logic [AW-1:0]          rd_ptr_r;
  logic [AW-1:0]          rd_ptr_nxt;
  logic [CHAR_BITS-1:0]   rd_data_r;

  logic                   in_ready;
  logic                   out_valid;
  logic                   wr_en;
  logic                   rd_en;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [REM_W-1:0]       div_remainder;

  // Digit buffer, written least significant digit first and read back in reverse.
  logic [CHAR_BITS-1:0]   digit_mem [VALUE_WIDTH];

  // The first division starts straight from the input value; later ones start from
  // the quotient that the divider left behind.
  assign div_dividend    = (state_r == ST_IDLE) ? in_ch.value[VALUE_WIDTH-1:0] : div_quotient;

  rdsc_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .rsp       (div_rsp),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ndig_r   <= '0;
      rd_ptr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ndig_r   <= ndig_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // The radix is held for the whole item; the divider reads it on every step.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      radix_r <= radix_clamp(in_ch.radix);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[ndig_r] <= digit_char_f(div_remainder);
    end
    if (rd_en) begin
      rd_data_r <= digit_mem[rd_ptr_r];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ndig_nxt        = ndig_r;
    rd_ptr_nxt      = rd_ptr_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = radix_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          div_req.start = 1'b1;
          ndig_nxt      = '0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          wr_en = 1'b1;
          // A zero quotient means this remainder was the most significant digit.
          if (div_rsp.quo_zero) begin
            rd_ptr_nxt = ndig_r;
            state_nxt  = ST_READ;
          end else begin
            div_req.start = 1'b1;
            ndig_nxt      = AW'(ndig_r + 1'b1);
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ch.ready) begin
          if (rd_ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r - 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.digit_char = rd_data_r;
  assign out_ch.last       = (rd_ptr_r == '0);

endmodule

// ===== design/rdsc_checker.sv =====
// Port-level checker for the radix digit string converter and its bind statement.
`timescale 1ns / 1ps
`include "radix_digit_string_converter_unit_defines.svh"

module rdsc_checker import rdsc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHAR_BITS-1:0] out_digit_char,
  input logic                 out_last
);

  // A digit that waits for the sink stays offered, with its last flag unchanged.
  `RDSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_last))

  // Every digit is an ASCII character in '0'..'9' or 'a'..'z'.
  `RDSC_ASSERT_IMP(a_char_range, clk, rst_n, out_valid, (out_digit_char >= 7'd48 && out_digit_char <= 7'd57) || (out_digit_char >= 7'd97 && out_digit_char <= 7'd122))

  // No new item is taken while digits of the previous one are still pending.
  `RDSC_ASSERT_IMP(a_one_item, clk, rst_n, out_valid, !in_ready)

  // The first digit needs at least one full division after an item is taken.
  `RDSC_ASSERT_NXT(a_no_early_digit, clk, rst_n, in_valid && in_ready, !out_valid)

endmodule

bind radix_digit_string_converter_unit rdsc_checker u_rdsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_digit_char (out_ch.digit_char),
  .out_last       (out_ch.last)
);

// ===== verif/radix_digit_string_converter_unit_test.sv =====
// Self-checking testbench for the radix digit string converter unit.
`timescale 1ns / 1ps

// The testbench converts unsigned values to digit strings and checks the results.
// One task sends a value and a radix over the input channel. At the edge where the
// transfer happens, it predicts the ASCII digits of that value, most significant
// first, and appends them to a queue of expected digits. A checker process compares
// each output transfer, field by field, with the oldest expected digit.
// The unit holds one item at a time, so the tests differ only
// in the values they send and in how both channel ends idle and stall:
//   - directed edge cases: zero, all ones, single digits and letter digits, and a
//     radix below two or above thirty-six, which is clamped to the nearest end;
//   - random values with random radixes, most of them short so the run stays fast;
//   - a stretch with no idling on either side;
//   - a long receiver hold-off while the sender keeps offering items;
//   - a sender pause until every expected digit has arrived.

module radix_digit_string_converter_unit_test;
  import rdsc_pkg::*;

  localparam int CONV_WIDTH       = 64;
  localparam int HOLD_OFF_CYCLES  = 3000;
  localparam int IDLE_PERCENT     = 20;
  localparam int SETTLE_CYCLES    = 300;
  localparam int DRAIN_LIMIT      = 200000;

  // One predicted digit of a converted value.
  typedef struct {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
  } digit_exp_t;

  logic clk = 1'b0;
  logic rst_n;

  rdsc_in_if  in_bus ();
  rdsc_out_if out_bus ();

  radix_digit_string_converter_unit #(
    .VALUE_WIDTH(CONV_WIDTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus.sink),
    .out_ch(out_bus.source)
  );

  // Digits that the unit still owes, oldest first.
  digit_exp_t expected_digits[$];

  // Controls shared between the test tasks and the receiver process.
  bit source_idles = 1'b1;
  bit sink_idles   = 1'b1;
  bit sink_hold_req = 1'b0;

  // Run statistics.
  int unsigned error_count      = 0;
  int unsigned values_sent      = 0;
  int unsigned digits_checked   = 0;
  int unsigned clamped_radixes  = 0;
  int unsigned longest_string   = 0;
  int unsigned input_stall_cyc  = 0;
  int unsigned hold_offs_done   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Safety net: even the slowest legal run finishes far sooner than this.
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Works out the digit string of one value and queues it for the checker. The
  // radix is clamped to 2..36 and only the low CONV_WIDTH bits of the value count.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                         input logic [RADIX_BITS-1:0] radix);
    logic [VALUE_BITS-1:0] rest;
    logic [VALUE_BITS-1:0] base;
    logic [VALUE_BITS-1:0] rem;
    logic [CHAR_BITS-1:0]  chars[$];
    digit_exp_t            rec;
    rest = value & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - CONV_WIDTH));
    if (radix < RADIX_MIN) begin
      base = VALUE_BITS'(RADIX_MIN);
      clamped_radixes++;
    end else if (radix > RADIX_MAX) begin
      base = VALUE_BITS'(RADIX_MAX);
      clamped_radixes++;
    end else begin
      base = VALUE_BITS'(radix);
    end
    // Remainders come out least significant first, so each new one goes in front.
    do begin
      rem  = rest % base;
      rest = rest / base;
      if (rem < 10) begin
        chars.push_front(CHAR_ZERO + rem[CHAR_BITS-1:0]);
      end else begin
        chars.push_front(LETTER_OFFSET + rem[CHAR_BITS-1:0]);
      end
    end while (rest != 0);
    if (chars.size() > longest_string) begin
      longest_string = chars.size();
    end
    foreach (chars[i]) begin
      rec.digit_char = chars[i];
      rec.last       = (i == chars.size() - 1);
      expected_digits.push_back(rec);
    end
  endfunction

  // Offers one value and radix until the unit takes it. The valid line is left high
  // after the transfer; the next call or a pause lowers it, so valid never gets two
  // assignments in one time step.
  task automatic send_number(input logic [VALUE_BITS-1:0] value,
                             input logic [RADIX_BITS-1:0] radix);
    while (source_idles && $urandom_range(99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= value;
    in_bus.radix <= radix;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    predict_digits(value, radix);
    values_sent++;
  endtask

  // Drops valid and waits until every expected digit has come out.
  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_digits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_digits.size() != 0) begin
      $error("digits still missing after drain: %0d", expected_digits.size());
      error_count++;
    end
  endtask

  // A value whose bit length is random; most are short, a few reach the full width.
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned           len;
    logic [VALUE_BITS-1:0] raw;
    if ($urandom_range(99) < 85) begin
      len = $urandom_range(24, 0);
    end else begin
      len = $urandom_range(VALUE_BITS, 25);
    end
    raw = {$urandom, $urandom};
    if (len == 0) begin
      return '0;
    end
    return raw & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - len));
  endfunction

  // Mostly legal radixes, with the whole 6-bit range mixed in.
  function automatic logic [RADIX_BITS-1:0] random_radix();
    if ($urandom_range(99) < 80) begin
      return RADIX_BITS'($urandom_range(RADIX_MAX, RADIX_MIN));
    end
    return RADIX_BITS'($urandom_range(63, 0));
  endfunction

  // Receiver: random ready, or a long hold-off counted here when a test asks for it.
  initial begin
    int unsigned held;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (sink_hold_req) begin
        out_bus.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          @(posedge clk);
        end
        sink_hold_req = 1'b0;
        hold_offs_done++;
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= !(sink_idles && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Checker: every output transfer must match the oldest expected digit.
  always @(posedge clk) begin
    digit_exp_t want;
    if (rst_n) begin
      if (in_bus.valid && !in_bus.ready) begin
        input_stall_cyc++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected digit transfer: digit_char=%0d last=%0b",
                 out_bus.digit_char, out_bus.last);
          error_count++;
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (out_bus.digit_char !== want.digit_char) begin
            $error("digit_char mismatch: expected %0d, actual %0d",
                   want.digit_char, out_bus.digit_char);
            error_count++;
          end
          if (out_bus.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_bus.last);
            error_count++;
          end
        end
      end
    end
  end

  // Edge cases of the value and radix fields, and the clamped radixes.
  task automatic test_directed();
    send_number(64'd0, 6'd10);                   // zero gives a lone '0'
    send_number(64'd0, 6'd2);
    send_number({VALUE_BITS{1'b1}}, 6'd2);       // longest string: 64 ones
    send_number({VALUE_BITS{1'b1}}, 6'd10);
    send_number({VALUE_BITS{1'b1}}, 6'd16);
    send_number({VALUE_BITS{1'b1}}, 6'd36);
    send_number(64'h8000_0000_0000_0000, 6'd8);  // only the top bit set
    send_number(64'd1, 6'd36);
    send_number(64'd9, 6'd10);                   // last decimal digit
    send_number(64'd10, 6'd11);                  // first letter digit
    send_number(64'd35, 6'd36);                  // highest letter digit
    send_number(64'd36, 6'd36);                  // rolls over to "10"
    send_number(64'd255, 6'd16);
    send_number(64'd5, 6'd0);                    // radix below two acts as binary
    send_number(64'd6, 6'd1);
    send_number(64'd1295, 6'd37);                // radix above thirty-six acts as 36
    send_number({VALUE_BITS{1'b1}}, 6'd63);
    send_number(64'h5555_5555_5555_5555, 6'd3);
    wait_for_drain();
  endtask

  task automatic test_random_values(input int unsigned count);
    repeat (count) begin
      send_number(random_value(), random_radix());
    end
  endtask

  // Both ends run flat out: back-to-back items and an always-ready receiver.
  task automatic test_no_idle_stretch();
    source_idles = 1'b0;
    sink_idles   = 1'b0;
    test_random_values(20);
    wait_for_drain();
    source_idles = 1'b1;
    sink_idles   = 1'b1;
  endtask

  // The receiver stops for a long time while items keep coming, so the unit fills
  // up with digits and holds its input back.
  task automatic test_output_hold_off();
    sink_hold_req = 1'b1;
    repeat (5) begin
      send_number({$urandom, $urandom}, 6'd16);
    end
    wait_for_drain();
  endtask

  // The sender goes quiet until the unit has delivered everything, then resumes.
  task automatic test_sender_pause();
    test_random_values(4);
    wait_for_drain();
    test_random_values(4);
    wait_for_drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.value <= '0;
    in_bus.radix <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_values(90);
    test_no_idle_stretch();
    test_output_hold_off();
    test_sender_pause();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d with a clamped radix) into %0d checked digits.",
             values_sent, clamped_radixes, digits_checked);
    $display("Longest string %0d digits; input held back %0d cycles over %0d hold-offs.",
             longest_string, input_stall_cyc, hold_offs_done);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
